### src/cspt_pkg.sv
// Shared types and constants for the channel silence and peak tracker.
package cspt_pkg;

  // Field widths fixed by the transaction format
  localparam int MAP_W    = 32;
  localparam int CH_W     = 5;
  localparam int SMP_W    = 24;
  localparam int THR_W    = 23;
  localparam int CNT_W    = 6;
  localparam int CFG_IDX_W = 2;

  // Default channel count
  localparam int CHANNELS_DEF = 32;

  // Register reset values
  localparam logic [THR_W-1:0] THRESH_RST = 23'd1200;  // about 1.431e-4 in Q0.23
  localparam logic             TRACK_RST  = 1'b0;
  localparam logic [CNT_W-1:0] ACTIVE_RST = 6'd2;

  // Request codes
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_SET    = 2'd1,
    REQ_MERGE  = 2'd2
  } req_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_TRACK_EN  = 2'd1,
    CFG_ACTIVE    = 2'd2
  } cfg_idx_t;

  // Input transaction
  typedef struct packed {
    req_t                     req_type;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W-1:0]  sample;
    logic                     last_frame;
    logic [MAP_W-1:0]         channel_mask;
  } cspt_in_t;

  // Result transaction
  typedef struct packed {
    logic [MAP_W-1:0] silence_map;
    logic             channel_quiet;
    logic [SMP_W-1:0] peak_level;
    logic             any_noise;
  } cspt_out_t;

  // Live configuration handed to the tracking core
  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             tracking_enable;
    logic [CNT_W-1:0] active_channels;
    logic             active_upd;      // strobe set together with each write of active_channels
  } cspt_cfg_t;

endpackage

### src/cspt_cfg_regs.sv
// Configuration register file of the channel silence and peak tracker.
module cspt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cspt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspt_pkg::THR_W-1:0]      cfg_data,
  output cspt_pkg::cspt_cfg_t             cfg
);
  import cspt_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic             track_en_r;
  logic [CNT_W-1:0] active_r;
  logic             active_upd_r;
  logic             wr;

  // Writes are always accepted
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESH_RST;
      track_en_r   <= TRACK_RST;
      active_r     <= ACTIVE_RST;
      active_upd_r <= 1'b0;
    end else begin
      active_upd_r <= 1'b0;
      if (wr) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: threshold_r <= cfg_data;
          CFG_TRACK_EN:  track_en_r  <= cfg_data[0];
          CFG_ACTIVE: begin
            active_r     <= cfg_data[CNT_W-1:0];
            active_upd_r <= 1'b1;
          end
          default: ;  // unknown index, ignored
        endcase
      end
    end
  end

  assign cfg.threshold       = threshold_r;
  assign cfg.tracking_enable = track_en_r;
  assign cfg.active_channels = active_r;
  assign cfg.active_upd      = active_upd_r;

endmodule

### src/cspt_in_stage.sv
// Input register stage: captures one transaction and holds it until the core takes it.
module cspt_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cspt_pkg::cspt_in_t in_data,
  output logic               item_valid,
  output cspt_pkg::cspt_in_t item,
  input  logic               take
);
  import cspt_pkg::*;

  logic     in_v_r;
  cspt_in_t in_r;
  logic     accept;

  // Stall only while a held item cannot move on
  assign in_stall = in_v_r & ~take;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
  end

  assign item_valid = in_v_r;
  assign item       = in_r;

endmodule

### src/cspt_track_core.sv
// Per-channel quiet/peak accumulators, silence map and result register.
module cspt_track_core #(
  parameter int CHANNELS = cspt_pkg::CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cspt_pkg::cspt_cfg_t cfg,
  input  logic                item_valid,
  input  cspt_pkg::cspt_in_t  item,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output cspt_pkg::cspt_out_t out_data
);
  import cspt_pkg::*;

  // Channels with storage: never more than the map has bits
  localparam int NCH   = (CHANNELS > MAP_W) ? MAP_W : CHANNELS;
  localparam int IDX_W = $clog2(NCH);
  localparam logic [CNT_W-1:0] NCH_CNT = CNT_W'(NCH);

  logic [MAP_W-1:0] map_r;
  logic             quiet_r [NCH];
  logic [SMP_W-1:0] peak_r  [NCH];
  logic             out_v_r;
  cspt_out_t        out_r;

  logic             fire;
  logic [CNT_W-1:0] eff;
  logic [MAP_W:0]   ones_ext;
  logic [MAP_W:0]   inact_ext;
  logic [MAP_W-1:0] inact;
  logic             ch_ok;
  logic [IDX_W-1:0] idx;
  logic             q_cur;
  logic [SMP_W-1:0] p_cur;
  logic [SMP_W-1:0] mag;
  logic             below;
  logic             q_acc;
  logic [SMP_W-1:0] p_acc;
  logic [MAP_W-1:0] bit_sel;
  logic [MAP_W-1:0] map_nxt;
  logic [MAP_W-1:0] map_fin;
  logic [SMP_W-1:0] peak_o;
  logic             acc_wr;
  logic             q_wr;
  logic [SMP_W-1:0] p_wr;

  // Advance when the result register is free or being drained
  assign take = ~out_v_r | ~out_stall;
  assign fire = item_valid & take;

  // Effective channel count and the mask of bits forced silent
  assign eff       = (cfg.active_channels > NCH_CNT) ? NCH_CNT : cfg.active_channels;
  assign ones_ext  = '1;
  assign inact_ext = ones_ext << eff;
  assign inact     = inact_ext[MAP_W-1:0];

  // Channel lookup; out-of-range channels are ignored
  assign ch_ok   = {1'b0, item.channel} < eff;
  assign idx     = item.channel[IDX_W-1:0];
  assign q_cur   = ch_ok ? quiet_r[idx] : 1'b1;
  assign p_cur   = ch_ok ? peak_r[idx]  : '0;
  assign bit_sel = MAP_W'(1) << item.channel;

  // Magnitude: full-scale negative maps to 2^23, which fits unsigned
  assign mag   = item.sample[SMP_W-1] ? (~item.sample + SMP_W'(1)) : item.sample;
  assign below = mag < {1'b0, cfg.threshold};
  assign q_acc = q_cur & below;
  assign p_acc = (mag > p_cur) ? mag : p_cur;

  // Map update and accumulator write-back
  always_comb begin
    map_nxt = map_r;
    peak_o  = '0;
    acc_wr  = 1'b0;
    q_wr    = q_acc;
    p_wr    = p_acc;
    case (item.req_type)
      REQ_SAMPLE: begin
        if (ch_ok) begin
          if (cfg.tracking_enable) begin
            acc_wr = 1'b1;
            if (item.last_frame) begin
              if (q_acc) begin
                map_nxt = map_r | bit_sel;
              end else begin
                map_nxt = map_r & ~bit_sel;
                peak_o  = p_acc;
              end
              q_wr = 1'b1;
              p_wr = '0;
            end
          end else if (item.last_frame) begin
            map_nxt = map_r & ~bit_sel;
          end
        end
      end
      REQ_SET:   map_nxt = map_r | item.channel_mask;
      REQ_MERGE: map_nxt = map_r & item.channel_mask;
      default:   ;  // unused code leaves state alone
    endcase
  end

  assign map_fin = map_nxt | inact;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r <= '1;
      for (int i = 0; i < NCH; i++) begin
        quiet_r[i] <= 1'b1;
        peak_r[i]  <= '0;
      end
    end else begin
      if (fire) begin
        map_r <= map_fin;
        if (acc_wr) begin
          quiet_r[idx] <= q_wr;
          peak_r[idx]  <= p_wr;
        end
      end else if (cfg.active_upd) begin
        map_r <= map_r | inact;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.silence_map   <= map_fin;
      out_r.channel_quiet <= map_fin[item.channel];
      out_r.peak_level    <= peak_o;
      out_r.any_noise     <= |(~map_fin & item.channel_mask);
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### src/channel_silence_peak_tracker_top.sv
// An accepted input passes the input register and then the result register to result valid.
// Throughput: one transaction per cycle unless stalled; the per-channel read-modify-write of
//   the quiet flag and peak is done in one logic stage, so same-channel items may follow.
// Reset (rst_n low, synchronous): silence map all ones, quiet flags set, peaks zero,
//   threshold 1200, tracking off, two active channels, input and result registers empty.
// Top level of the channel silence and peak tracker.
module channel_silence_peak_tracker_top #(
  parameter int CHANNELS = cspt_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cspt_pkg::cspt_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cspt_pkg::cspt_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cspt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cspt_pkg::THR_W-1:0]      cfg_data
);
  import cspt_pkg::*;

  cspt_cfg_t cfg;
  logic      item_valid;
  cspt_in_t  item;
  logic      take;

  cspt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cspt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  cspt_track_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
